// ===== rtl/core/hdspe_pkg.sv =====
// Shared types and constants for the half-duplex servo packet engine.
`timescale 1ns / 1ps

package hdspe_pkg;

  localparam int MAX_PACKET = 32;
  localparam logic [5:0] LEN_MIN = 6'd6;
  localparam logic [5:0] LEN_CAP = (MAX_PACKET > 63) ? 6'd63 : 6'(MAX_PACKET);
  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] SUM_OK = 8'hFF;
  localparam logic [15:0] TIMEOUT_RST = 16'd1500;
  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLARITY = 1'd1;

  typedef enum logic [1:0] {
    ACT_SEND = 2'd0,
    ACT_LINE = 2'd1,
    ACT_TICK = 2'd2,
    ACT_ARM  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    RX_OK      = 2'd0,
    RX_TIMEOUT = 2'd1,
    RX_BAD_SUM = 2'd2,
    RX_SERVO   = 2'd3
  } rx_status_t;

  typedef enum logic {
    KIND_TX = 1'b0,
    KIND_RX = 1'b1
  } kind_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  byte_value;
    logic        last_byte;
    logic [5:0]  expect_length;
  } in_item_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  line_byte;
    logic        drive_level;
    rx_status_t  rx_status;
    logic [7:0]  error_code;
    logic [15:0] read_value;
    logic        last_result;
  } out_item_t;

  // One queued job: a transmit burst or a receive report.
  typedef struct packed {
    kind_t       kind;
    logic        hdr;       // prepend the two sync bytes
    logic [7:0]  data;
    logic        chk;       // append checksum byte
    logic [7:0]  chk_byte;
    logic        lvl;       // direction level for header/data or the report
    rx_status_t  status;
    logic [7:0]  err;
    logic [15:0] val;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== rtl/core/half_duplex_servo_packet_engine.sv =====
// Top level of the half-duplex servo bus packet engine.
`timescale 1ns / 1ps

// The front end takes one request per clock as long as its two-entry job
// queue has room; arming and ignored line bytes or ticks produce no job.
// The result sequencer emits one result per clock for the job it holds,
// through a registered output, while the output is not stalled; a send
// request yields one to four results (sync bytes, data byte, checksum) and
// a receive report one. The sequencer fetches the next job only once it is
// idle, so it cannot start a new job before it is through with the last one.
// Configuration writes are always ready.
module half_duplex_servo_packet_engine import hdspe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [15:0] timeout_r;
  logic        polarity_r;
  q_status_t   q_stat;
  logic        q_push, q_pop;
  job_t        push_job, head_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RST;
      polarity_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TIMEOUT:  timeout_r  <= cfg_data[15:0];
        CFG_POLARITY: polarity_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  hdspe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .timeout_ticks  (timeout_r),
    .drive_polarity (polarity_r),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  hdspe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  hdspe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/hdspe_front.sv =====
// Front end: accepts requests, tracks transmit/receive state, queues jobs.
`timescale 1ns / 1ps

module hdspe_front import hdspe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  input  logic [15:0] timeout_ticks,
  input  logic       drive_polarity,
  input  q_status_t  q_stat,
  output logic       q_push,
  output job_t       q_job
);

  logic        tx_busy_r, tx_busy_nxt;
  logic [7:0]  tx_sum_r, tx_sum_nxt;
  logic        rx_armed_r, rx_armed_nxt;
  logic [5:0]  rx_expected_r, rx_expected_nxt;
  logic [5:0]  rx_count_r, rx_count_nxt;
  logic [7:0]  rx_sum_r, rx_sum_nxt;
  logic [7:0]  rx_err_r, rx_err_nxt;
  logic [7:0]  rx_lo_r, rx_lo_nxt;
  logic [7:0]  rx_hi_r, rx_hi_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic        accept;
  logic [7:0]  sum_inc;
  logic [5:0]  len_clamped;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  always_comb begin
    tx_busy_nxt     = tx_busy_r;
    tx_sum_nxt      = tx_sum_r;
    rx_armed_nxt    = rx_armed_r;
    rx_expected_nxt = rx_expected_r;
    rx_count_nxt    = rx_count_r;
    rx_sum_nxt      = rx_sum_r;
    rx_err_nxt      = rx_err_r;
    rx_lo_nxt       = rx_lo_r;
    rx_hi_nxt       = rx_hi_r;
    elapsed_nxt     = elapsed_r;
    q_push          = 1'b0;
    q_job           = '0;
    q_job.kind      = KIND_TX;
    q_job.status    = RX_OK;
    q_job.lvl       = tx_busy_r ? drive_polarity : ~drive_polarity;
    sum_inc         = tx_sum_r + in_data.byte_value;
    len_clamped     = in_data.expect_length;
    if (len_clamped < LEN_MIN) len_clamped = LEN_MIN;
    if (len_clamped > LEN_CAP) len_clamped = LEN_CAP;

    if (accept) begin
      case (in_data.action)
        ACT_SEND: begin
          q_push         = 1'b1;
          q_job.kind     = KIND_TX;
          q_job.hdr      = !tx_busy_r;
          q_job.data     = in_data.byte_value;
          q_job.chk      = in_data.last_byte;
          q_job.chk_byte = ~sum_inc;
          q_job.lvl      = drive_polarity;
          tx_busy_nxt    = !in_data.last_byte;
          tx_sum_nxt     = in_data.last_byte ? 8'd0 : sum_inc;
        end
        ACT_ARM: begin
          rx_armed_nxt    = 1'b1;
          rx_expected_nxt = len_clamped;
          rx_count_nxt    = '0;
          rx_sum_nxt      = '0;
          rx_err_nxt      = '0;
          rx_lo_nxt       = '0;
          rx_hi_nxt       = '0;
          elapsed_nxt     = '0;
        end
        ACT_TICK: begin
          if (rx_armed_r) begin
            if (elapsed_r != TICK_MAX) elapsed_nxt = elapsed_r + 16'd1;
            if (elapsed_nxt >= timeout_ticks) begin
              rx_armed_nxt = 1'b0;
              q_push       = 1'b1;
              q_job.kind   = KIND_RX;
              q_job.status = RX_TIMEOUT;
            end
          end
        end
        default: begin
          if (rx_armed_r) begin
            if (rx_count_r >= 6'd2) rx_sum_nxt = rx_sum_r + in_data.byte_value;
            case (rx_count_r)
              6'd4:    rx_err_nxt = in_data.byte_value;
              6'd5:    rx_lo_nxt  = in_data.byte_value;
              6'd6:    rx_hi_nxt  = in_data.byte_value;
              default: ;
            endcase
            rx_count_nxt = rx_count_r + 6'd1;
            if (rx_count_nxt >= rx_expected_r) begin
              rx_armed_nxt = 1'b0;
              q_push       = 1'b1;
              q_job.kind   = KIND_RX;
              q_job.err    = rx_err_nxt;
              if (rx_sum_nxt != SUM_OK) begin
                q_job.status = RX_BAD_SUM;
              end else begin
                q_job.status = (rx_err_nxt != 8'd0) ? RX_SERVO : RX_OK;
                if (rx_expected_r == 6'd7) q_job.val = {8'd0, rx_lo_nxt};
                else if (rx_expected_r > 6'd7) q_job.val = {rx_hi_nxt, rx_lo_nxt};
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_busy_r     <= 1'b0;
      tx_sum_r      <= '0;
      rx_armed_r    <= 1'b0;
      rx_expected_r <= LEN_MIN;
      rx_count_r    <= '0;
      rx_sum_r      <= '0;
      rx_err_r      <= '0;
      rx_lo_r       <= '0;
      rx_hi_r       <= '0;
      elapsed_r     <= '0;
    end else begin
      tx_busy_r     <= tx_busy_nxt;
      tx_sum_r      <= tx_sum_nxt;
      rx_armed_r    <= rx_armed_nxt;
      rx_expected_r <= rx_expected_nxt;
      rx_count_r    <= rx_count_nxt;
      rx_sum_r      <= rx_sum_nxt;
      rx_err_r      <= rx_err_nxt;
      rx_lo_r       <= rx_lo_nxt;
      rx_hi_r       <= rx_hi_nxt;
      elapsed_r     <= elapsed_nxt;
    end
  end

endmodule

// ===== rtl/core/hdspe_queue.sv =====
// Short job queue between the front end and the result sequencer.
`timescale 1ns / 1ps

module hdspe_queue import hdspe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head_job,
  output q_status_t stat
);

  job_t             mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0]  count_r;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == Q_CW'(Q_DEPTH));
  assign head_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push || pop)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> !pop)
    else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(Q_DEPTH))
    else $error("queue count out of range");

endmodule

// ===== rtl/core/hdspe_back.sv =====
// Result sequencer: expands queued jobs into line bytes and receive reports.
`timescale 1ns / 1ps

module hdspe_back import hdspe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_status_t q_stat,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    ST_HDR0,
    ST_HDR1,
    ST_DATA,
    ST_CHK,
    ST_RPT
  } step_t;

  logic      active_r;
  step_t     step_r, step_nxt;
  job_t      job_r;
  out_item_t out_r, res;
  logic      out_valid_r;
  logic      emit, is_last;

  assign q_pop     = !active_r && !q_stat.empty;
  assign emit      = active_r && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    res             = '0;
    res.result_kind = KIND_TX;
    res.rx_status   = RX_OK;
    res.drive_level = job_r.lvl;
    is_last         = 1'b0;
    step_nxt        = step_r;
    case (step_r)
      ST_HDR0: begin
        res.line_byte = SYNC_BYTE;
        step_nxt      = ST_HDR1;
      end
      ST_HDR1: begin
        res.line_byte = SYNC_BYTE;
        step_nxt      = ST_DATA;
      end
      ST_DATA: begin
        res.line_byte = job_r.data;
        is_last       = !job_r.chk;
        step_nxt      = ST_CHK;
      end
      ST_CHK: begin
        // the checksum byte already goes out with the line released
        res.line_byte   = job_r.chk_byte;
        res.drive_level = ~job_r.lvl;
        is_last         = 1'b1;
      end
      default: begin
        res.result_kind = KIND_RX;
        res.rx_status   = job_r.status;
        res.error_code  = job_r.err;
        res.read_value  = job_r.val;
        is_last         = 1'b1;
      end
    endcase
    res.last_result = is_last;
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_job;
    if (emit)  out_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      step_r      <= ST_RPT;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        active_r <= 1'b1;
        if (q_job.kind == KIND_RX) step_r <= ST_RPT;
        else if (q_job.hdr)        step_r <= ST_HDR0;
        else                       step_r <= ST_DATA;
      end else if (emit) begin
        if (is_last) active_r <= 1'b0;
        step_r <= step_nxt;
      end
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  a_report_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.result_kind == KIND_RX) |-> out_r.last_result)
    else $error("receive report not marked last");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !emit)
    else $error("job fetched while sequencing");

  a_release_after_chk: assert property (@(posedge clk) disable iff (!rst_n)
    emit && (step_r == ST_CHK) |=> !active_r)
    else $error("sequencer busy after checksum byte");

endmodule

// ===== tb/tb_half_duplex_servo_packet_engine.sv =====
// Self-checking testbench for the half-duplex servo packet engine: framing, status parsing, timeouts.
`timescale 1ns / 1ps

module tb_half_duplex_servo_packet_engine;
  import hdspe_pkg::*;

  localparam int RESET_CYCLES = 9;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 20;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 70;
  // byte positions inside a status packet
  localparam int POS_SUM_START = 2;
  localparam int POS_ERROR = 4;
  localparam int POS_DATA_LO = 5;
  localparam int POS_DATA_HI = 6;
  localparam int LEN_ONE_DATA = 7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  half_duplex_servo_packet_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [15:0] timeout_limit = TIMEOUT_RST;
  logic        dir_polarity = 1'b0;
  logic        tx_open = 1'b0;
  logic [7:0]  tx_csum = '0;
  logic        rx_on = 1'b0;
  logic [5:0]  rx_len = LEN_MIN;
  logic [5:0]  rx_cnt = '0;
  logic [7:0]  rx_csum = '0;
  logic [7:0]  rx_err = '0;
  logic [7:0]  rx_lo = '0;
  logic [7:0]  rx_hi = '0;
  logic [15:0] rx_ticks = '0;

  out_item_t pending_results[$];
  int fail_count = 0;
  int items_used = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_hold = 0;
  int quiet_cycles = 0;

  function automatic out_item_t make_result(kind_t kind, logic [7:0] line, rx_status_t st,
                                            logic [7:0] err, logic [15:0] val);
    out_item_t r;
    r.result_kind = kind;
    r.line_byte = line;
    r.drive_level = tx_open ? dir_polarity : ~dir_polarity;
    r.rx_status = st;
    r.error_code = err;
    r.read_value = val;
    r.last_result = 1'b0;
    return r;
  endfunction

  // Updates the engine state for one accepted request and queues the results it causes.
  task automatic predict_engine(input in_item_t req);
    out_item_t batch[$];
    logic [5:0] len;
    rx_status_t st;
    logic [15:0] val;
    case (req.action)
      ACT_SEND: begin
        if (!tx_open) begin
          tx_open = 1'b1;
          tx_csum = '0;
          batch.push_back(make_result(KIND_TX, SYNC_BYTE, RX_OK, 8'h00, 16'h0000));
          batch.push_back(make_result(KIND_TX, SYNC_BYTE, RX_OK, 8'h00, 16'h0000));
        end
        batch.push_back(make_result(KIND_TX, req.byte_value, RX_OK, 8'h00, 16'h0000));
        tx_csum += req.byte_value;
        if (req.last_byte) begin
          // checksum goes out with the receive level already
          tx_open = 1'b0;
          batch.push_back(make_result(KIND_TX, ~tx_csum, RX_OK, 8'h00, 16'h0000));
          tx_csum = '0;
        end
      end
      ACT_ARM: begin
        len = req.expect_length;
        if (len < LEN_MIN) len = LEN_MIN;
        if (len > LEN_CAP) len = LEN_CAP;
        rx_on = 1'b1;
        rx_len = len;
        rx_cnt = '0;
        rx_csum = '0;
        rx_err = '0;
        rx_lo = '0;
        rx_hi = '0;
        rx_ticks = '0;
      end
      ACT_TICK: begin
        if (rx_on) begin
          if (rx_ticks != TICK_MAX) rx_ticks++;
          if (rx_ticks >= timeout_limit) begin
            rx_on = 1'b0;
            batch.push_back(make_result(KIND_RX, 8'h00, RX_TIMEOUT, 8'h00, 16'h0000));
          end
        end
      end
      default: begin
        if (rx_on) begin
          if (rx_cnt >= POS_SUM_START) rx_csum += req.byte_value;
          if (rx_cnt == POS_ERROR) rx_err = req.byte_value;
          else if (rx_cnt == POS_DATA_LO) rx_lo = req.byte_value;
          else if (rx_cnt == POS_DATA_HI) rx_hi = req.byte_value;
          rx_cnt++;
          if (rx_cnt >= rx_len) begin
            rx_on = 1'b0;
            if (rx_csum != SUM_OK) st = RX_BAD_SUM;
            else if (rx_err != 8'h00) st = RX_SERVO;
            else st = RX_OK;
            val = '0;
            if (st != RX_BAD_SUM) begin
              if (rx_len == LEN_ONE_DATA) val = {8'h00, rx_lo};
              else if (rx_len > LEN_ONE_DATA) val = {rx_hi, rx_lo};
            end
            batch.push_back(make_result(KIND_RX, 8'h00, st, rx_err, val));
          end
        end
      end
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last_result = 1'b1;
    foreach (batch[i]) pending_results.push_back(batch[i]);
  endtask

  function automatic in_item_t make_item(action_t act, logic [7:0] b, logic lst, logic [5:0] len);
    in_item_t it;
    it.action = act;
    it.byte_value = b;
    it.last_byte = lst;
    it.expect_length = len;
    return it;
  endfunction

  // Offers one request and returns at the edge that accepts it; valid stays high.
  task automatic push_request(input in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!((req.action == ACT_LINE || req.action == ACT_TICK) && !rx_on)) items_used++;
    predict_engine(req);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst);
    push_request(make_item(ACT_SEND, b, lst, 6'($urandom)));
  endtask

  task automatic send_tick();
    push_request(make_item(ACT_TICK, 8'($urandom), 1'($urandom), 6'($urandom)));
  endtask

  task automatic arm_receive(input logic [5:0] len);
    push_request(make_item(ACT_ARM, 8'($urandom), 1'($urandom), len));
  endtask

  // Drops valid, waits for every expected result, then lets the pipeline go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_TIMEOUT) timeout_limit = value;
    else dir_polarity = value[0];
  endtask

  // Feeds the first keep bytes of a status packet of length len; bytes two onward sum to
  // 0xFF unless bad_sum. Ticks and outgoing payload bytes are mixed in at random.
  task automatic feed_status(input int len, input bit bad_sum, input bit servo_err,
                             input int keep, input int tick_pct, input int tx_pct);
    logic [7:0] pkt[64];
    logic [7:0] sum;
    int k;
    sum = '0;
    for (int i = 0; i < 2; i++) pkt[i] = ($urandom_range(9) == 0) ? 8'($urandom) : SYNC_BYTE;
    pkt[2] = 8'($urandom);
    pkt[3] = 8'(len - 4);
    pkt[POS_ERROR] = servo_err ? 8'($urandom_range(1, 255)) : 8'h00;
    for (int i = POS_DATA_LO; i < len - 1; i++) pkt[i] = 8'($urandom);
    for (int i = POS_SUM_START; i < len - 1; i++) sum += pkt[i];
    pkt[len-1] = SUM_OK - sum;
    if (bad_sum) begin
      k = $urandom_range(POS_SUM_START, len - 1);
      pkt[k] ^= 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < keep; i++) begin
      if ($urandom_range(99) < tick_pct) send_tick();
      if ($urandom_range(99) < tx_pct) send_byte(8'($urandom), 1'($urandom));
      push_request(make_item(ACT_LINE, pkt[i], 1'($urandom), 6'($urandom)));
    end
  endtask

  function automatic int clamp_len(logic [5:0] len);
    if (len < LEN_MIN) return LEN_MIN;
    if (len > LEN_CAP) return LEN_CAP;
    return len;
  endfunction

  task automatic test_tx_framing();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h81, 1'b1);
  endtask

  task automatic test_status_receive();
    // line byte and tick with nothing armed are dropped
    push_request(make_item(ACT_LINE, 8'hFF, 1'b1, 6'h3F));
    send_tick();
    arm_receive(6'd0);
    feed_status(LEN_MIN, 1'b0, 1'b0, 2, 0, 0);
    // re-arm mid-packet restarts collection; bad checksum wins over a servo error
    arm_receive(6'd7);
    feed_status(LEN_ONE_DATA, 1'b1, 1'b1, LEN_ONE_DATA, 0, 0);
  endtask

  task automatic test_zero_timeout();
    write_reg(CFG_TIMEOUT, 16'd0);
    arm_receive(6'd8);
    send_tick();
    send_tick();
  endtask

  task automatic test_output_backpressure();
    settle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    stall_hold = HOLD_CYCLES;
    for (int i = 0; i < 16; i++) send_byte(8'($urandom), (i % 4) == 3);
  endtask

  task automatic random_sequence();
    int pick;
    int n;
    int len;
    logic [5:0] req_len;
    pick = $urandom_range(99);
    if (pick < 35) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) send_byte(8'($urandom), (i == n - 1) && ($urandom_range(9) != 0));
    end else if (pick < 85) begin
      n = $urandom_range(99);
      if (n < 60) req_len = 6'($urandom_range(6, 9));
      else if (n < 80) req_len = 6'($urandom_range(10, 32));
      else if (n < 90) req_len = 6'($urandom_range(0, 5));
      else req_len = 6'($urandom_range(33, 63));
      len = clamp_len(req_len);
      arm_receive(req_len);
      if (pick < 75) begin
        feed_status(len, $urandom_range(99) < 15, $urandom_range(99) < 25, len, 10, 8);
      end else begin
        // truncated packet, then let it time out when that is cheap
        feed_status(len, 1'b0, 1'($urandom), $urandom_range(0, len - 1), 10, 8);
        while (rx_on && timeout_limit <= 64) send_tick();
      end
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        push_request(make_item(action_t'($urandom_range(3)), 8'($urandom), 1'($urandom),
                               6'($urandom)));
    end
  endtask

  task automatic test_random_traffic();
    int send_pct[4] = '{0, 86, 0, 34};
    int recv_pct[4] = '{0, 0, 86, 34};
    logic [15:0] tmo[4] = '{16'd20, 16'hFFFF, 16'd9, TIMEOUT_RST};
    int target;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_TIMEOUT, tmo[ph]);
      write_reg(CFG_POLARITY, {15'($urandom), ph[0] ^ 1'b1});
      send_idle_pct = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      target = items_used + PHASE_ITEMS;
      while (items_used < target) random_sequence();
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Checks each accepted result and drives the stall for the next cycle.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %p", $time, out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", want.result_kind, out_data.result_kind);
        check_field("line_byte", want.line_byte, out_data.line_byte);
        check_field("drive_level", want.drive_level, out_data.drive_level);
        check_field("rx_status", want.rx_status, out_data.rx_status);
        check_field("error_code", want.error_code, out_data.error_code);
        check_field("read_value", want.read_value, out_data.read_value);
        check_field("last_result", want.last_result, out_data.last_result);
      end
    end
    if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Ends the run if no request, result or register write moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_tx_framing();
    test_status_receive();
    test_zero_timeout();
    test_output_backpressure();
    test_random_traffic();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
